/* design/ssa_pkg.sv */
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared constants, action codes and types of the sparse scatter-accumulate
// unit.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int SSA_TABLE_ROWS = 1024;
    localparam int SSA_LATENT_DIM = 8;

    localparam int SSA_IDX_W   = 10;
    localparam int SSA_LAT_W   = 3;
    localparam int SSA_VAL_W   = 16;
    localparam int SSA_PROD_W  = 32;
    localparam int SSA_ACC_W   = 48;
    localparam int SSA_ACT_W   = 2;
    localparam int SSA_S_DATA_W = 40;
    localparam int SSA_M_DATA_W = 48;
    localparam int SSA_PADDR_W = 3;
    localparam int SSA_PDATA_W = 32;

    localparam logic [SSA_ACT_W-1:0] SSA_ACT_LOAD  = 2'd0;
    localparam logic [SSA_ACT_W-1:0] SSA_ACT_CLEAR = 2'd1;
    localparam logic [SSA_ACT_W-1:0] SSA_ACT_ACCUM = 2'd2;
    localparam logic [SSA_ACT_W-1:0] SSA_ACT_READ  = 2'd3;

    localparam logic [SSA_PADDR_W-1:0] SSA_REG_DIRECTION = 3'd0;

    typedef struct packed {
        logic busy;
        logic sat;
    } ssa_mac_status_t;

endpackage

/* design/ssa_ram.sv */
// ----------------------------------------------------------------------------
// ssa_ram
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module ssa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/ssa_mac.sv */
// ----------------------------------------------------------------------------
// ssa_mac
// Multiply and saturating accumulate pipeline. Takes the factor and
// accumulator words read for one element and returns the updated
// accumulator word for write-back, summed from the registered product.
// ----------------------------------------------------------------------------
module ssa_mac
    import ssa_pkg::*;
#(
    parameter int ADDR_W = 13
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        issue_valid,
    input  logic [ADDR_W-1:0]           issue_addr,
    input  logic signed [SSA_VAL_W-1:0] value,
    input  logic [SSA_VAL_W-1:0]        factor_rdata,
    input  logic [SSA_ACC_W-1:0]        accum_rdata,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [SSA_ACC_W-1:0]        wr_data,
    output ssa_mac_status_t             status
);

    logic                         v1_reg;
    logic                         v2_reg;
    logic [ADDR_W-1:0]            a1_reg;
    logic [ADDR_W-1:0]            a2_reg;
    logic signed [SSA_PROD_W-1:0] prod_reg;
    logic [SSA_ACC_W-1:0]         acc_reg;
    logic [SSA_ACC_W:0]           sum;
    logic                         ovf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= issue_valid;
            v2_reg <= v1_reg;
        end
        a1_reg   <= issue_addr;
        a2_reg   <= a1_reg;
        prod_reg <= $signed(factor_rdata) * value;
        acc_reg  <= accum_rdata;
    end

    assign sum = {acc_reg[SSA_ACC_W-1], acc_reg}
               + {{(SSA_ACC_W + 1 - SSA_PROD_W){prod_reg[SSA_PROD_W-1]}}, prod_reg};
    assign ovf = sum[SSA_ACC_W] != sum[SSA_ACC_W-1];

    always_comb begin
        if (!ovf) begin
            wr_data = sum[SSA_ACC_W-1:0];
        end else if (sum[SSA_ACC_W]) begin
            wr_data = {1'b1, {(SSA_ACC_W-1){1'b0}}};
        end else begin
            wr_data = {1'b0, {(SSA_ACC_W-1){1'b1}}};
        end
    end

    assign wr_en       = v2_reg;
    assign wr_addr     = a2_reg;
    assign status.busy = v1_reg | v2_reg;
    assign status.sat  = v2_reg & ovf;

endmodule

/* design/sparse_scatter_accumulate_unit.sv */
// ----------------------------------------------------------------------------
// sparse_scatter_accumulate_unit
// Coordinate-form sparse times dense scatter-accumulate over a factor RAM and
// an accumulator RAM, one read-modify-write of the accumulator per element.
// ----------------------------------------------------------------------------
// Each word passes from S_IDLE to S_DONE and then to the result register:
// load directly, read via S_READ, accumulate via S_ACC and S_DRAIN, clear via
// S_CLEAR, which zeroes every accumulator word. One word is in work at a time;
// S_ACC issues one element per cycle, and S_DONE waits for a free result
// register. After reset all 2**ADDR_W accumulator words (8192 by default) are
// swept to zero with s_tready low; configuration writes are taken.
// ----------------------------------------------------------------------------
module sparse_scatter_accumulate_unit
    import ssa_pkg::*;
#(
    parameter int TABLE_ROWS = SSA_TABLE_ROWS,
    parameter int LATENT_DIM = SSA_LATENT_DIM
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // APB configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [SSA_PADDR_W-1:0]  paddr,
    input  logic [SSA_PDATA_W-1:0]  pwdata,
    output logic [SSA_PDATA_W-1:0]  prdata,
    output logic                    pready,
    // Input words
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // row_index[9:0], col_index[19:10], latent_index[22:20], value[38:23]
    input  logic [SSA_S_DATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [SSA_ACT_W-1:0]    s_tuser,
    // Result words
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // accum_value[47:0]
    output logic [SSA_M_DATA_W-1:0] m_tdata,
    // saturated[0]
    output logic                    m_tuser
);

    localparam int ROW_W  = $clog2(TABLE_ROWS);
    localparam int LAT_W  = (LATENT_DIM > 1) ? $clog2(LATENT_DIM) : 1;
    localparam int ADDR_W = ROW_W + LAT_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int RCMP_W = 17;
    localparam int LCMP_W = 7;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_ACC,
        S_DRAIN,
        S_READ,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic                    direction_reg;
    logic [ADDR_W-1:0]       cnt_reg;
    logic [LAT_W-1:0]        k_reg;
    logic [SSA_ACT_W-1:0]    act_reg;
    logic                    ok_reg;
    logic                    sat_reg;
    logic [ROW_W-1:0]        frow_reg;
    logic [ROW_W-1:0]        arow_reg;
    logic [LAT_W-1:0]        lat_reg;
    logic signed [SSA_VAL_W-1:0] val_reg;
    logic                    m_tvalid_reg;
    logic [SSA_ACC_W-1:0]    m_value_reg;
    logic                    m_sat_reg;

    logic [SSA_ACT_W-1:0]    in_action;
    logic [SSA_IDX_W-1:0]    in_row;
    logic [SSA_IDX_W-1:0]    in_col;
    logic [SSA_LAT_W-1:0]    in_lat;
    logic [SSA_VAL_W-1:0]    in_value;
    logic                    in_accept;
    logic                    row_ok;
    logic                    col_ok;
    logic                    lat_ok;
    logic                    out_free;
    logic                    cfg_write;

    logic                    f_we;
    logic [ADDR_W-1:0]       f_waddr;
    logic [ADDR_W-1:0]       f_raddr;
    logic [SSA_VAL_W-1:0]    f_rdata;
    logic                    a_we;
    logic [ADDR_W-1:0]       a_waddr;
    logic [SSA_ACC_W-1:0]    a_wdata;
    logic [ADDR_W-1:0]       a_raddr;
    logic [SSA_ACC_W-1:0]    a_rdata;

    logic                    mac_we;
    logic [ADDR_W-1:0]       mac_waddr;
    logic [SSA_ACC_W-1:0]    mac_wdata;
    ssa_mac_status_t         mac_status;

    assign in_action = s_tuser;
    assign in_row    = s_tdata[9:0];
    assign in_col    = s_tdata[19:10];
    assign in_lat    = s_tdata[22:20];
    assign in_value  = s_tdata[38:23];

    assign s_tready  = state_reg == S_IDLE;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign row_ok = RCMP_W'(in_row) < RCMP_W'(TABLE_ROWS);
    assign col_ok = RCMP_W'(in_col) < RCMP_W'(TABLE_ROWS);
    assign lat_ok = LCMP_W'(in_lat) < LCMP_W'(LATENT_DIM);

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr == SSA_REG_DIRECTION) ?
                       {{(SSA_PDATA_W-1){1'b0}}, direction_reg} : '0;

    assign f_we    = in_accept && (in_action == SSA_ACT_LOAD) && row_ok && lat_ok;
    assign f_waddr = {ROW_W'(in_row), LAT_W'(in_lat)};
    assign f_raddr = {frow_reg, k_reg};
    assign a_raddr = {arow_reg, (state_reg == S_ACC) ? k_reg : lat_reg};

    always_comb begin
        if (state_reg == S_INIT || state_reg == S_CLEAR) begin
            a_we    = 1'b1;
            a_waddr = cnt_reg;
            a_wdata = '0;
        end else begin
            a_we    = mac_we;
            a_waddr = mac_waddr;
            a_wdata = mac_wdata;
        end
    end

    ssa_ram #(
        .WIDTH (SSA_VAL_W),
        .DEPTH (DEPTH)
    ) u_factor_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (in_value),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    ssa_ram #(
        .WIDTH (SSA_ACC_W),
        .DEPTH (DEPTH)
    ) u_accum_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    ssa_mac #(
        .ADDR_W (ADDR_W)
    ) u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .issue_valid  (state_reg == S_ACC),
        .issue_addr   ({arow_reg, k_reg}),
        .value        (val_reg),
        .factor_rdata (f_rdata),
        .accum_rdata  (a_rdata),
        .wr_en        (mac_we),
        .wr_addr      (mac_waddr),
        .wr_data      (mac_wdata),
        .status       (mac_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            direction_reg <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            sat_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_write && paddr == SSA_REG_DIRECTION) begin
                direction_reg <= pwdata[0];
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (mac_status.sat) begin
                sat_reg <= 1'b1;
            end

            case (state_reg)
                S_INIT: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (&cnt_reg) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        act_reg  <= in_action;
                        val_reg  <= in_value;
                        lat_reg  <= LAT_W'(in_lat);
                        sat_reg  <= 1'b0;
                        k_reg    <= '0;
                        cnt_reg  <= '0;
                        frow_reg <= direction_reg ? ROW_W'(in_col) : ROW_W'(in_row);
                        arow_reg <= (in_action == SSA_ACT_ACCUM && !direction_reg) ?
                                    ROW_W'(in_col) : ROW_W'(in_row);
                        case (in_action)
                            SSA_ACT_LOAD: begin
                                ok_reg    <= 1'b0;
                                state_reg <= S_DONE;
                            end
                            SSA_ACT_CLEAR: begin
                                ok_reg    <= 1'b0;
                                state_reg <= S_CLEAR;
                            end
                            SSA_ACT_ACCUM: begin
                                ok_reg    <= row_ok && col_ok;
                                state_reg <= (row_ok && col_ok) ? S_ACC : S_DONE;
                            end
                            SSA_ACT_READ: begin
                                ok_reg    <= row_ok && lat_ok;
                                state_reg <= S_READ;
                            end
                            default: begin
                                ok_reg    <= 1'b0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (&cnt_reg) begin
                        state_reg <= S_DONE;
                    end
                end
                S_ACC: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == LAT_W'(LATENT_DIM - 1)) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!mac_status.busy) begin
                        state_reg <= S_DONE;
                    end
                end
                S_READ: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_value_reg  <= (act_reg == SSA_ACT_READ && ok_reg) ? a_rdata : '0;
                        m_sat_reg    <= sat_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_sat_reg;

endmodule
